FILE: hdl/hcw_pkg.sv
// hcw_pkg: shared types, constants and lookup functions for the hilbert curve walker
// used by hcw_stack, hcw_turtle and hilbert_curve_walker_core; no dependencies
package hcw_pkg;

    localparam int MAX_ORDER = 15;
    localparam int LVL_W     = 4;
    localparam int POS_W     = 4;
    localparam int COORD_W   = 15;
    localparam int TILE_W    = 3;
    localparam int ORDER_W   = 4;

    localparam logic [POS_W-1:0]   RULE_LEN   = 4'd11;
    localparam logic [ORDER_W-1:0] ORDER_RST  = 4'd6;
    localparam logic [COORD_W-1:0] START_Y_RST = 15'd63;

    typedef enum logic [2:0] {
        SYM_A,
        SYM_B,
        SYM_F,
        SYM_L,
        SYM_R
    } sym_t;

    typedef enum logic [1:0] {
        DIR_RIGHT,
        DIR_DOWN,
        DIR_LEFT,
        DIR_UP
    } dir_t;

    typedef enum logic [2:0] {
        STK_NONE,
        STK_INIT,
        STK_ADV,
        STK_PUSH,
        STK_POP
    } stk_op_t;

    typedef enum logic [2:0] {
        TRT_NONE,
        TRT_INIT,
        TRT_LEFT,
        TRT_RIGHT,
        TRT_MOVE
    } trt_op_t;

    typedef struct packed {
        stk_op_t op;
        logic    push_rule;
    } stk_cmd_t;

    typedef struct packed {
        trt_op_t            op;
        logic [COORD_W-1:0] init_y;
    } trt_cmd_t;

    // rule A is -BF+AFA+FB-, rule B is its mirror (A<->B, -<->+)
    function automatic sym_t rule_sym(input logic rule_b, input logic [POS_W-1:0] pos);
        sym_t s;
        unique case (pos)
            4'd0:    s = SYM_L;
            4'd1:    s = SYM_B;
            4'd2:    s = SYM_F;
            4'd3:    s = SYM_R;
            4'd4:    s = SYM_A;
            4'd5:    s = SYM_F;
            4'd6:    s = SYM_A;
            4'd7:    s = SYM_R;
            4'd8:    s = SYM_F;
            4'd9:    s = SYM_B;
            4'd10:   s = SYM_L;
            default: s = SYM_F;
        endcase
        if (rule_b)
        begin
            unique case (s)
                SYM_A:   s = SYM_B;
                SYM_B:   s = SYM_A;
                SYM_L:   s = SYM_R;
                SYM_R:   s = SYM_L;
                default: s = s;
            endcase
        end
        return s;
    endfunction

    function automatic logic [TILE_W-1:0] tile_of(input dir_t from, input dir_t to);
        logic [TILE_W-1:0] t;
        unique case ({from, to})
            {DIR_RIGHT, DIR_DOWN},  {DIR_DOWN, DIR_RIGHT}: t = 3'd4;
            {DIR_RIGHT, DIR_LEFT},  {DIR_LEFT, DIR_RIGHT}: t = 3'd2;
            {DIR_RIGHT, DIR_UP},    {DIR_UP, DIR_RIGHT}:   t = 3'd3;
            {DIR_DOWN, DIR_LEFT},   {DIR_LEFT, DIR_DOWN}:  t = 3'd5;
            {DIR_DOWN, DIR_UP},     {DIR_UP, DIR_DOWN}:    t = 3'd1;
            {DIR_LEFT, DIR_UP},     {DIR_UP, DIR_LEFT}:    t = 3'd6;
            default:                                       t = 3'd0;
        endcase
        return t;
    endfunction

endpackage

FILE: hdl/hcw_stack.sv
// hcw_stack: rule and symbol position per recursion level, with the level pointer
// depends on hcw_pkg
module hcw_stack (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hcw_pkg::stk_cmd_t             cmd,
    output logic [hcw_pkg::LVL_W-1:0]     level,
    output logic                          top_rule,
    output logic [hcw_pkg::POS_W-1:0]     top_pos
);

    logic                      rule_reg [hcw_pkg::MAX_ORDER];
    logic [hcw_pkg::POS_W-1:0] pos_reg  [hcw_pkg::MAX_ORDER];
    logic [hcw_pkg::LVL_W-1:0] level_reg;
    logic [hcw_pkg::LVL_W-1:0] level_up;

    assign level_up = level_reg + hcw_pkg::LVL_W'(1);
    assign level    = level_reg;
    assign top_rule = rule_reg[level_reg];
    assign top_pos  = pos_reg[level_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            for (int i = 0; i < hcw_pkg::MAX_ORDER; i++)
            begin
                rule_reg[i] <= 1'b0;
                pos_reg[i]  <= '0;
            end
        end
        else
        begin
            unique case (cmd.op)
                hcw_pkg::STK_INIT:
                begin
                    level_reg <= '0;
                    for (int i = 0; i < hcw_pkg::MAX_ORDER; i++)
                    begin
                        rule_reg[i] <= 1'b0;
                        pos_reg[i]  <= '0;
                    end
                end
                hcw_pkg::STK_ADV:
                begin
                    pos_reg[level_reg] <= pos_reg[level_reg] + hcw_pkg::POS_W'(1);
                end
                hcw_pkg::STK_PUSH:
                begin
                    pos_reg[level_reg] <= pos_reg[level_reg] + hcw_pkg::POS_W'(1);
                    pos_reg[level_up]  <= '0;
                    rule_reg[level_up] <= cmd.push_rule;
                    level_reg          <= level_up;
                end
                hcw_pkg::STK_POP:
                begin
                    pos_reg[level_reg] <= '0;
                    level_reg          <= level_reg - hcw_pkg::LVL_W'(1);
                end
                default:
                begin
                    level_reg <= level_reg;
                end
            endcase
        end
    end

endmodule

FILE: hdl/hcw_turtle.sv
// hcw_turtle: turtle pose (heading, previous direction, cell position) and tile lookup
// depends on hcw_pkg
module hcw_turtle (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hcw_pkg::trt_cmd_t             cmd,
    output logic [hcw_pkg::COORD_W-1:0]   pos_x,
    output logic [hcw_pkg::COORD_W-1:0]   pos_y,
    output logic [hcw_pkg::TILE_W-1:0]    tile
);

    hcw_pkg::dir_t               heading_reg;
    hcw_pkg::dir_t               came_from_reg;
    logic [hcw_pkg::COORD_W-1:0] pos_x_reg;
    logic [hcw_pkg::COORD_W-1:0] pos_y_reg;

    assign pos_x = pos_x_reg;
    assign pos_y = pos_y_reg;
    assign tile  = hcw_pkg::tile_of(came_from_reg, heading_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heading_reg   <= hcw_pkg::DIR_RIGHT;
            came_from_reg <= hcw_pkg::DIR_DOWN;
            pos_x_reg     <= '0;
            pos_y_reg     <= hcw_pkg::START_Y_RST;
        end
        else
        begin
            unique case (cmd.op)
                hcw_pkg::TRT_INIT:
                begin
                    heading_reg   <= hcw_pkg::DIR_RIGHT;
                    came_from_reg <= hcw_pkg::DIR_DOWN;
                    pos_x_reg     <= '0;
                    pos_y_reg     <= cmd.init_y;
                end
                hcw_pkg::TRT_LEFT:
                begin
                    heading_reg <= hcw_pkg::dir_t'(heading_reg - 2'd1);
                end
                hcw_pkg::TRT_RIGHT:
                begin
                    heading_reg <= hcw_pkg::dir_t'(heading_reg + 2'd1);
                end
                hcw_pkg::TRT_MOVE:
                begin
                    unique case (heading_reg)
                        hcw_pkg::DIR_RIGHT: pos_x_reg <= pos_x_reg + hcw_pkg::COORD_W'(1);
                        hcw_pkg::DIR_DOWN:  pos_y_reg <= pos_y_reg + hcw_pkg::COORD_W'(1);
                        hcw_pkg::DIR_LEFT:  pos_x_reg <= pos_x_reg - hcw_pkg::COORD_W'(1);
                        default:            pos_y_reg <= pos_y_reg - hcw_pkg::COORD_W'(1);
                    endcase
                    came_from_reg <= hcw_pkg::dir_t'(heading_reg + 2'd2);
                end
                default:
                begin
                    heading_reg <= heading_reg;
                end
            endcase
        end
    end

endmodule

FILE: hdl/hilbert_curve_walker_core.sv
// hilbert_curve_walker_core: top level, symbol sequencer and output register
// depends on hcw_pkg, hcw_stack, hcw_turtle
//
// usage
// - input channel (in_valid/in_stall, restart): one item requests the next cell;
//   restart=1 first puts the walker back at the bottom-left cell heading right
// - output channel (out_valid/out_stall): one item per input item with cell_x,
//   cell_y, tile, last_cell and idle; idle=1 once the curve has ended
// - cfg_we/cfg_wdata write curve_order (0 acts as 1); write only while idle
// - an accepted item enters the sequencer, which then consumes one grammar symbol
//   per cycle (turns, pushes, pops, and the final forward move) through the
//   single stack read/write port; the forward move and the final cell wait while
//   the output register is stalled, and an item on an ended curve consumes no
//   symbols and yields the idle result
// - in_stall is high while an item is being worked on; the result waits in an
//   output register, so the next item is accepted while it is still pending
// - a result that finds the output register still stalled waits in the
//   sequencer until out_stall drops, without consuming further symbols
// - reset: curve_order 6, walker at its start, no result pending
module hilbert_curve_walker_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [hcw_pkg::ORDER_W-1:0]   cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          restart,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [hcw_pkg::COORD_W-1:0]   cell_x,
    output logic [hcw_pkg::COORD_W-1:0]   cell_y,
    output logic [hcw_pkg::TILE_W-1:0]    tile,
    output logic                          last_cell,
    output logic                          idle
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                        state_reg, state_next;
    logic [hcw_pkg::ORDER_W-1:0]   order_reg, order_next;
    logic                          finished_reg, finished_next;
    logic                          out_valid_reg, out_valid_next;
    logic [hcw_pkg::COORD_W-1:0]   cell_x_reg, cell_x_next;
    logic [hcw_pkg::COORD_W-1:0]   cell_y_reg, cell_y_next;
    logic [hcw_pkg::TILE_W-1:0]    tile_reg, tile_next;
    logic                          last_cell_reg, last_cell_next;
    logic                          idle_reg, idle_next;

    hcw_pkg::stk_cmd_t             stk_cmd;
    hcw_pkg::trt_cmd_t             trt_cmd;
    logic [hcw_pkg::LVL_W-1:0]     level;
    logic                          top_rule;
    logic [hcw_pkg::POS_W-1:0]     top_pos;
    logic [hcw_pkg::COORD_W-1:0]   pos_x;
    logic [hcw_pkg::COORD_W-1:0]   pos_y;
    logic [hcw_pkg::TILE_W-1:0]    cur_tile;

    logic [hcw_pkg::ORDER_W-1:0]   eff_order;
    logic [hcw_pkg::COORD_W-1:0]   start_y;
    logic                          can_push;
    logic                          in_accept;
    logic                          out_free;
    hcw_pkg::sym_t                 sym;

    hcw_stack u_stack (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (stk_cmd),
        .level    (level),
        .top_rule (top_rule),
        .top_pos  (top_pos)
    );

    hcw_turtle u_turtle (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (trt_cmd),
        .pos_x (pos_x),
        .pos_y (pos_y),
        .tile  (cur_tile)
    );

    assign eff_order = (order_reg == '0) ? hcw_pkg::ORDER_W'(1) : order_reg;
    assign start_y   = hcw_pkg::COORD_W'((16'd1 << eff_order) - 16'd1);
    assign can_push  = ({1'b0, level} + 5'd1) < {1'b0, eff_order};
    assign sym       = hcw_pkg::rule_sym(top_rule, top_pos);

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign cell_x    = cell_x_reg;
    assign cell_y    = cell_y_reg;
    assign tile      = tile_reg;
    assign last_cell = last_cell_reg;
    assign idle      = idle_reg;

    always_comb
    begin
        logic emit;
        emit           = 1'b0;
        state_next     = state_reg;
        order_next     = cfg_we ? cfg_wdata : order_reg;
        finished_next  = finished_reg;
        stk_cmd        = '{op: hcw_pkg::STK_NONE, push_rule: 1'b0};
        trt_cmd        = '{op: hcw_pkg::TRT_NONE, init_y: start_y};
        cell_x_next    = cell_x_reg;
        cell_y_next    = cell_y_reg;
        tile_next      = tile_reg;
        last_cell_next = last_cell_reg;
        idle_next      = idle_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (restart)
                    begin
                        stk_cmd.op    = hcw_pkg::STK_INIT;
                        trt_cmd.op    = hcw_pkg::TRT_INIT;
                        finished_next = 1'b0;
                    end
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (finished_reg)
                begin
                    if (out_free)
                    begin
                        emit           = 1'b1;
                        cell_x_next    = '0;
                        cell_y_next    = '0;
                        tile_next      = '0;
                        last_cell_next = 1'b0;
                        idle_next      = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else if (top_pos >= hcw_pkg::RULE_LEN)
                begin
                    if (level != '0)
                    begin
                        stk_cmd.op = hcw_pkg::STK_POP;
                    end
                    else if (out_free)
                    begin
                        // end of the top-level rule: final cell
                        emit           = 1'b1;
                        cell_x_next    = pos_x;
                        cell_y_next    = pos_y;
                        tile_next      = cur_tile;
                        last_cell_next = 1'b1;
                        idle_next      = 1'b0;
                        finished_next  = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    unique case (sym)
                        hcw_pkg::SYM_A, hcw_pkg::SYM_B:
                        begin
                            stk_cmd.op        = can_push ? hcw_pkg::STK_PUSH : hcw_pkg::STK_ADV;
                            stk_cmd.push_rule = (sym == hcw_pkg::SYM_B);
                        end
                        hcw_pkg::SYM_L:
                        begin
                            stk_cmd.op = hcw_pkg::STK_ADV;
                            trt_cmd.op = hcw_pkg::TRT_LEFT;
                        end
                        hcw_pkg::SYM_R:
                        begin
                            stk_cmd.op = hcw_pkg::STK_ADV;
                            trt_cmd.op = hcw_pkg::TRT_RIGHT;
                        end
                        default:
                        begin
                            if (out_free)
                            begin
                                stk_cmd.op     = hcw_pkg::STK_ADV;
                                trt_cmd.op     = hcw_pkg::TRT_MOVE;
                                emit           = 1'b1;
                                cell_x_next    = pos_x;
                                cell_y_next    = pos_y;
                                tile_next      = cur_tile;
                                last_cell_next = 1'b0;
                                idle_next      = 1'b0;
                                state_next     = ST_IDLE;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            order_reg     <= hcw_pkg::ORDER_RST;
            finished_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            order_reg     <= order_next;
            finished_reg  <= finished_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_x_reg    <= cell_x_next;
        cell_y_reg    <= cell_y_next;
        tile_reg      <= tile_next;
        last_cell_reg <= last_cell_next;
        idle_reg      <= idle_next;
    end

    a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_RUN))
        else $error("result appeared without an item in progress");

    a_idle_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(idle && last_cell))
        else $error("idle result also marked as last cell");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= hcw_pkg::LVL_W'(hcw_pkg::MAX_ORDER - 1))
        else $error("stack level beyond its depth");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && restart) |=> !finished_reg)
        else $error("restart did not clear the finished flag");

endmodule
